>>> rtl/core/ppds_pkg.sv
// Shared types and constants for the pixel PLL divider selection block.
// Used by the front end, the divider cells and the top level.
package ppds_pkg;

    localparam int CLK_W  = 19;
    localparam int HD_W   = 16;
    localparam int RDIV_W = 8;
    localparam int RFRQ_W = 16;
    localparam int N_W    = CLK_W + RDIV_W;
    localparam int D_W    = 21;
    localparam int M_W    = D_W + 8;
    localparam int CMP_W  = 31;
    localparam int Q_W    = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 19;

    localparam logic [HD_W-1:0]  QUIRK_WIDTH = 16'd1440;
    localparam logic [CLK_W-1:0] QUIRK_CLOCK = 19'd108000;

    localparam logic [CLK_W-1:0]  RST_MAX_CLK  = 19'd524287;
    localparam logic [RDIV_W-1:0] RST_REF_DIV  = 8'd33;
    localparam logic [RFRQ_W-1:0] RST_REF_FREQ = 16'd1432;
    localparam logic              RST_EXT_CHIP = 1'b1;

    localparam logic [1:0] PC_DIV1 = 2'd0;
    localparam logic [1:0] PC_DIV2 = 2'd1;
    localparam logic [1:0] PC_DIV4 = 2'd2;
    localparam logic [1:0] PC_DIV8 = 2'd3;

    localparam logic [3:0] PV_1  = 4'd1;
    localparam logic [3:0] PV_2  = 4'd2;
    localparam logic [3:0] PV_3  = 4'd3;
    localparam logic [3:0] PV_4  = 4'd4;
    localparam logic [3:0] PV_6  = 4'd6;
    localparam logic [3:0] PV_8  = 4'd8;
    localparam logic [3:0] PV_12 = 4'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_PIXEL_CLOCK = 4'd0,
        REG_REF_DIVIDER     = 4'd1,
        REG_REF_FREQUENCY   = 4'd2,
        REG_EXT_DIV_CHIP    = 4'd3
    } t_reg_idx;

    typedef struct packed {
        logic       quirk;
        logic       hi;
        logic       lo;
        logic       ext;
        logic [3:0] pdiv;
        logic [1:0] code;
    } t_side;

    typedef struct packed {
        logic [M_W-1:0] rem;
        logic [D_W-1:0] dv;
        logic [Q_W-1:0] quo;
        t_side          side;
    } t_div;

endpackage

>>> rtl/core/ppds_front.sv
// Front end: clamps the clock, forms the ratio terms and picks the post divider band.
// Four pipeline stages; depends on ppds_pkg.
module ppds_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [ppds_pkg::CLK_W-1:0]    i_pixel_clock,
    input  logic [ppds_pkg::HD_W-1:0]     i_h_display,
    input  logic [ppds_pkg::CLK_W-1:0]    i_max_clk,
    input  logic [ppds_pkg::RDIV_W-1:0]   i_ref_div,
    input  logic [ppds_pkg::RFRQ_W-1:0]   i_ref_freq,
    input  logic                          i_ext_chip,
    output logic                          o_valid,
    output ppds_pkg::t_div                o_data
);
    import ppds_pkg::*;

    logic             r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic [CLK_W-1:0] r_a_clk;
    logic             r_a_quirk, r_b_quirk, r_c_quirk;
    logic [N_W-1:0]   r_b_n;
    logic [D_W-1:0]   r_b_d;
    logic [N_W-1:0]   r_c_n;
    logic [M_W-1:0]   r_c_n3;
    logic [D_W-1:0]   r_c_d;
    logic [M_W-1:0]   r_c_d255;
    logic [M_W-1:0]   r_c_d85;
    t_div             r_d_data;

    logic [CLK_W-1:0] w_clk;
    logic [CMP_W-1:0] w_n, w_n2, w_n4, w_n8, w_n3, w_d255, w_d85, w_d16, w_d32;
    logic [CMP_W-1:0] w_m;
    t_side            w_side;

    assign w_clk = (i_pixel_clock > i_max_clk) ? i_max_clk : i_pixel_clock;

    assign w_n    = CMP_W'(r_c_n);
    assign w_n2   = w_n << 1;
    assign w_n4   = w_n << 2;
    assign w_n8   = w_n << 3;
    assign w_n3   = CMP_W'(r_c_n3);
    assign w_d255 = CMP_W'(r_c_d255);
    assign w_d85  = CMP_W'(r_c_d85);
    assign w_d16  = CMP_W'(r_c_d) << 4;
    assign w_d32  = CMP_W'(r_c_d) << 5;

    always_comb begin
        w_side       = '0;
        w_side.quirk = r_c_quirk;
        w_m          = '0;
        if ((r_c_d == '0) || (w_n > w_d255)) begin
            w_side.hi   = 1'b1;
            w_side.code = PC_DIV1;
            w_side.pdiv = PV_1;
        end else if (i_ext_chip) begin
            if (w_n2 > w_d255) begin
                w_side.code = PC_DIV1;
                w_side.pdiv = PV_1;
                w_m         = w_n;
            end else if (w_n > w_d85) begin
                w_side.code = PC_DIV2;
                w_side.pdiv = PV_2;
                w_m         = w_n2;
            end else if (w_n4 > w_d255) begin
                w_side.code = PC_DIV1;
                w_side.pdiv = PV_3;
                w_side.ext  = 1'b1;
                w_m         = w_n3;
            end else if (w_n2 > w_d85) begin
                w_side.code = PC_DIV4;
                w_side.pdiv = PV_4;
                w_m         = w_n4;
            end else if (w_n8 > w_d255) begin
                w_side.code = PC_DIV4;
                w_side.pdiv = PV_6;
                w_side.ext  = 1'b1;
                w_m         = w_n3 << 1;
            end else if (w_n4 > w_d85) begin
                w_side.code = PC_DIV8;
                w_side.pdiv = PV_8;
                w_m         = w_n8;
            end else begin
                w_side.code = PC_DIV8;
                w_side.pdiv = PV_12;
                w_side.ext  = 1'b1;
                w_side.lo   = (w_n3 < w_d32);
                w_m         = w_n3 << 2;
            end
        end else begin
            if (w_n2 > w_d255) begin
                w_side.code = PC_DIV1;
                w_side.pdiv = PV_1;
                w_m         = w_n;
            end else if (w_n4 > w_d255) begin
                w_side.code = PC_DIV2;
                w_side.pdiv = PV_2;
                w_m         = w_n2;
            end else if (w_n8 > w_d255) begin
                w_side.code = PC_DIV4;
                w_side.pdiv = PV_4;
                w_m         = w_n4;
            end else begin
                w_side.code = PC_DIV8;
                w_side.pdiv = PV_8;
                w_side.lo   = (w_n < w_d16);
                w_m         = w_n8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_clk   <= w_clk;
            r_a_quirk <= (i_h_display == QUIRK_WIDTH) && (w_clk < QUIRK_CLOCK);

            r_b_n     <= N_W'(r_a_clk) * N_W'(i_ref_div);
            r_b_d     <= (D_W'(i_ref_freq) << 4) + (D_W'(i_ref_freq) << 2);
            r_b_quirk <= r_a_quirk;

            r_c_n     <= r_b_n;
            r_c_n3    <= M_W'(r_b_n) + (M_W'(r_b_n) << 1);
            r_c_d     <= r_b_d;
            r_c_d255  <= (M_W'(r_b_d) << 8) - M_W'(r_b_d);
            r_c_d85   <= (M_W'(r_b_d) << 6) + (M_W'(r_b_d) << 4)
                         + (M_W'(r_b_d) << 2) + M_W'(r_b_d);
            r_c_quirk <= r_b_quirk;

            r_d_data.rem  <= w_m[M_W-1:0];
            r_d_data.dv   <= r_c_d;
            r_d_data.quo  <= '0;
            r_d_data.side <= w_side;
        end
    end

    assign o_valid = r_d_valid;
    assign o_data  = r_d_data;

endmodule

>>> rtl/core/ppds_div_cell.sv
// One cell of the restoring divider chain: resolves one quotient bit per item.
// Depends on ppds_pkg.
module ppds_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  ppds_pkg::t_div i_data,
    output logic           o_valid,
    output ppds_pkg::t_div o_data
);
    import ppds_pkg::*;

    logic           r_valid;
    t_div           r_data;
    logic [M_W:0]   w_sub;
    t_div           n_data;

    assign w_sub = {1'b0, i_data.rem} - ((M_W + 1)'(i_data.dv) << SHIFT);

    always_comb begin
        n_data = i_data;
        if (!w_sub[M_W]) begin
            n_data.rem        = w_sub[M_W-1:0];
            n_data.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/core/pixel_pll_divider_select.sv
// Throughput is one item per cycle while i_out_stall does not hold the pipeline.
// Four front stages clamp and band the ratio, eight divider cells give one quotient bit each,
// and an output register applies the 1440-wide adjustment.
// Reset is synchronous and active low; it empties the pipeline and restores register defaults.
module pixel_pll_divider_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ppds_pkg::CLK_W-1:0]        i_pixel_clock,
    input  logic [ppds_pkg::HD_W-1:0]         i_h_display,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_post_div_code,
    output logic [3:0]                        o_post_div_value,
    output logic                              o_extended_div,
    output logic [7:0]                        o_feedback_div,
    output logic                              o_ratio_too_high,
    output logic                              o_ratio_too_low,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ppds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ppds_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ppds_pkg::*;

    logic              r_out_valid;
    logic [CLK_W-1:0]  r_max_clk;
    logic [RDIV_W-1:0] r_ref_div;
    logic [RFRQ_W-1:0] r_ref_freq;
    logic              r_ext_chip;
    logic [1:0]        r_code;
    logic [3:0]        r_pdiv;
    logic              r_ext;
    logic [Q_W-1:0]    r_fb;
    logic              r_hi;
    logic              r_lo;

    logic              w_en;
    logic              w_valid [0:Q_W];
    t_div              w_data  [0:Q_W];
    logic [Q_W-1:0]    w_fb;

    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_clk  <= RST_MAX_CLK;
            r_ref_div  <= RST_REF_DIV;
            r_ref_freq <= RST_REF_FREQ;
            r_ext_chip <= RST_EXT_CHIP;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_MAX_PIXEL_CLOCK: r_max_clk  <= i_cfg_data[CLK_W-1:0];
                REG_REF_DIVIDER:     r_ref_div  <= i_cfg_data[RDIV_W-1:0];
                REG_REF_FREQUENCY:   r_ref_freq <= i_cfg_data[RFRQ_W-1:0];
                REG_EXT_DIV_CHIP:    r_ext_chip <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ppds_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_in_valid),
        .i_pixel_clock (i_pixel_clock),
        .i_h_display   (i_h_display),
        .i_max_clk     (r_max_clk),
        .i_ref_div     (r_ref_div),
        .i_ref_freq    (r_ref_freq),
        .i_ext_chip    (r_ext_chip),
        .o_valid       (w_valid[0]),
        .o_data        (w_data[0])
    );

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        ppds_div_cell #(
            .SHIFT (Q_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    always_comb begin
        w_fb = w_data[Q_W].side.hi ? {Q_W{1'b1}} : w_data[Q_W].quo;
        if (w_data[Q_W].side.quirk) begin
            w_fb = w_fb - Q_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_code <= w_data[Q_W].side.code;
            r_pdiv <= w_data[Q_W].side.pdiv;
            r_ext  <= w_data[Q_W].side.ext;
            r_fb   <= w_fb;
            r_hi   <= w_data[Q_W].side.hi;
            r_lo   <= w_data[Q_W].side.lo;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_post_div_code  = r_code;
    assign o_post_div_value = r_pdiv;
    assign o_extended_div   = r_ext;
    assign o_feedback_div   = r_fb;
    assign o_ratio_too_high = r_hi;
    assign o_ratio_too_low  = r_lo;

`ifndef SYNTHESIS
    a_hi_band : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_hi) |-> (r_code == PC_DIV1 && r_pdiv == PV_1 && !r_ext && !r_lo))
        else $error("ratio too high without the undivided band");

    a_lo_band : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_lo) |-> (r_code == PC_DIV8 && (r_pdiv == PV_8 || r_pdiv == PV_12)))
        else $error("ratio too low outside the lowest band");

    a_ext_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ext) |-> (r_pdiv == PV_3 || r_pdiv == PV_6 || r_pdiv == PV_12))
        else $error("extended divider with a power-of-two value");

    a_chain_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_valid[Q_W]) |=> r_out_valid)
        else $error("item lost between the divider chain and the output register");
`endif

endmodule
